// File: rtl/core/ieee_float_hex_string_formatter_core_assert.svh
// assertion macros shared by the hex float formatter modules
// no dependencies; taken in by the controller and the datapath
`ifndef IEEE_FLOAT_HEX_STRING_FORMATTER_CORE_ASSERT_SVH
`define IEEE_FLOAT_HEX_STRING_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IHF_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IHF_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ihf_pkg.sv
// types, constants and character helpers for the hex float formatter
// no dependencies; imported by ihf_ctrl, ihf_datapath and the top level
`default_nettype none

package ihf_pkg;

  // field widths
  localparam int unsigned SIG_W  = 52;
  localparam int unsigned EXP_W  = 11;
  localparam int unsigned BCD_W  = 16;
  localparam int unsigned CHAR_W = 7;

  // binary to bcd conversion takes one step per exponent bit
  localparam logic [3:0] CONV_STEPS = 4'd11;

  // exponent biases and subnormal exponent magnitudes
  localparam logic [EXP_W-1:0] BIAS_SP    = 11'd127;
  localparam logic [EXP_W-1:0] BIAS_DP    = 11'd1023;
  localparam logic [EXP_W-1:0] SUB_MAG_SP = 11'd126;
  localparam logic [EXP_W-1:0] SUB_MAG_DP = 11'd1022;

  // fixed ascii characters
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_P     = 7'h70;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_SIGN,
    S_ZERO,
    S_X,
    S_LEAD,
    S_DOT,
    S_FRAC,
    S_P,
    S_EMINUS,
    S_EXP,
    S_WORD
  } state_t;

  // character source selected by the controller
  typedef enum logic [3:0] {
    SEL_MINUS,
    SEL_ZERO,
    SEL_X,
    SEL_LEAD,
    SEL_DOT,
    SEL_FRAC,
    SEL_P,
    SEL_EXP,
    SEL_WORD
  } char_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      conv;
    logic      align;
    logic      emit;
    logic      last;
    char_sel_t sel;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic conv_done;
    logic neg;
    logic is_nan;
    logic is_inf;
    logic exp_neg;
    logic frac_last;
    logic exp_last;
    logic word_last;
  } dp_status_t;

  // lowercase hex digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, v};
    if (v < 4'd10) begin
      return CH_ZERO + ext;
    end else begin
      return 7'h57 + ext;
    end
  endfunction

  // characters of the words NaN and Infinity
  function automatic logic [CHAR_W-1:0] word_char(input logic nan, input logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    c = CH_ZERO;
    if (nan) begin
      case (idx)
        3'd0:    c = 7'h4e;
        3'd1:    c = 7'h61;
        3'd2:    c = 7'h4e;
        default: c = CH_ZERO;
      endcase
    end else begin
      case (idx)
        3'd0:    c = 7'h49;
        3'd1:    c = 7'h6e;
        3'd2:    c = 7'h66;
        3'd3:    c = 7'h69;
        3'd4:    c = 7'h6e;
        3'd5:    c = 7'h69;
        3'd6:    c = 7'h74;
        3'd7:    c = 7'h79;
        default: c = CH_ZERO;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ihf_ctrl.sv
// sequencer for the hex float formatter: walks the parts of the text
// depends on ihf_pkg and the assertion macro header
`default_nettype none

`include "ieee_float_hex_string_formatter_core_assert.svh"

module ihf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               value_valid,
  output logic                    value_stall,
  input  wire ihf_pkg::dp_status_t stat,
  output ihf_pkg::ctrl_cmd_t      cmd
);
  import ihf_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.sel     = SEL_ZERO;
    value_stall = 1'b1;
    case (state)
      S_IDLE: begin
        value_stall = 1'b0;
        if (value_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (!stat.conv_done) begin
          cmd.conv = 1'b1;
        end else begin
          cmd.align = 1'b1;
          if (stat.is_nan) begin
            state_next = S_WORD;
          end else if (stat.neg) begin
            state_next = S_SIGN;
          end else if (stat.is_inf) begin
            state_next = S_WORD;
          end else begin
            state_next = S_ZERO;
          end
        end
      end
      S_SIGN: begin
        cmd.sel  = SEL_MINUS;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = stat.is_inf ? S_WORD : S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.sel  = SEL_ZERO;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = S_X;
        end
      end
      S_X: begin
        cmd.sel  = SEL_X;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = S_LEAD;
        end
      end
      S_LEAD: begin
        cmd.sel  = SEL_LEAD;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = S_DOT;
        end
      end
      S_DOT: begin
        cmd.sel  = SEL_DOT;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = S_FRAC;
        end
      end
      S_FRAC: begin
        cmd.sel  = SEL_FRAC;
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.frac_last) begin
          state_next = S_P;
        end
      end
      S_P: begin
        cmd.sel  = SEL_P;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = stat.exp_neg ? S_EMINUS : S_EXP;
        end
      end
      S_EMINUS: begin
        cmd.sel  = SEL_MINUS;
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = S_EXP;
        end
      end
      S_EXP: begin
        cmd.sel  = SEL_EXP;
        cmd.emit = stat.out_free;
        cmd.last = stat.exp_last;
        if (stat.out_free && stat.exp_last) begin
          state_next = S_IDLE;
        end
      end
      S_WORD: begin
        cmd.sel  = SEL_WORD;
        cmd.emit = stat.out_free;
        cmd.last = stat.word_last;
        if (stat.out_free && stat.word_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  `IHF_ASSERT_NXT(a_load_to_conv, clk, rst, cmd.load, state == S_CONV, "load must start conversion")
  `IHF_ASSERT_NXT(a_conv_holds, clk, rst, (state == S_CONV) && !stat.conv_done, state == S_CONV, "conversion left early")
  `IHF_ASSERT_NXT(a_last_ends, clk, rst, cmd.emit && cmd.last, state == S_IDLE, "last character did not end the text")

endmodule

`default_nettype wire

// File: rtl/core/ihf_datapath.sv
// datapath of the hex float formatter: decode, bcd conversion, output register
// depends on ihf_pkg and the assertion macro header
`default_nettype none

`include "ieee_float_hex_string_formatter_core_assert.svh"

module ihf_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic                        precision_mode,
  input  wire logic [63:0]                 value_bits,
  input  wire ihf_pkg::ctrl_cmd_t          cmd,
  output ihf_pkg::dp_status_t              stat,
  output logic                             char_valid,
  input  wire logic                        char_stall,
  output logic [ihf_pkg::CHAR_W-1:0]       char_code,
  output logic                             last_char
);
  import ihf_pkg::*;

  logic             mode;
  logic             neg;
  logic             is_nan;
  logic             is_inf;
  logic             lead_one;
  logic             exp_neg;
  logic [SIG_W-1:0] sig;
  logic [EXP_W-1:0] bin;
  logic [BCD_W-1:0] bcd;
  logic [3:0]       conv_cnt;
  logic [1:0]       dcnt;
  logic [2:0]       widx;

  // decode of the incoming value
  logic             d_neg;
  logic [EXP_W-1:0] d_exp;
  logic             d_exp_max;
  logic             d_frac_zero;
  logic [SIG_W-1:0] d_sig;
  logic [EXP_W-1:0] d_bias;
  logic [EXP_W-1:0] d_sub_mag;
  logic [EXP_W:0]   d_diff;
  logic [EXP_W-1:0] d_mag;
  logic             d_exp_neg;

  // conversion and emission helpers
  logic [BCD_W-1:0]  bcd_adj;
  logic [CHAR_W-1:0] ch;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_write) begin
      mode <= precision_mode;
    end
  end

  // field split by precision
  always_comb begin
    if (mode) begin
      d_neg       = value_bits[63];
      d_exp       = value_bits[62:52];
      d_exp_max   = &value_bits[62:52];
      d_frac_zero = (value_bits[51:0] == '0);
      d_sig       = value_bits[51:0];
      d_bias      = BIAS_DP;
      d_sub_mag   = SUB_MAG_DP;
    end else begin
      d_neg       = value_bits[31];
      d_exp       = {3'b000, value_bits[30:23]};
      d_exp_max   = &value_bits[30:23];
      d_frac_zero = (value_bits[22:0] == '0);
      d_sig       = {value_bits[22:0], 29'd0};
      d_bias      = BIAS_SP;
      d_sub_mag   = SUB_MAG_SP;
    end
    d_diff = {1'b0, d_exp} - {1'b0, d_bias};
    if (d_exp == '0) begin
      d_exp_neg = !d_frac_zero;
      d_mag     = d_frac_zero ? '0 : d_sub_mag;
    end else begin
      d_exp_neg = d_diff[EXP_W];
      d_mag     = d_diff[EXP_W] ? (~d_diff[EXP_W-1:0] + 11'd1) : d_diff[EXP_W-1:0];
    end
  end

  // add three to every bcd digit of five or more
  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? (bcd[i*4 +: 4] + 4'd3) : bcd[i*4 +: 4];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= d_neg;
      is_nan   <= d_exp_max && !d_frac_zero;
      is_inf   <= d_exp_max && d_frac_zero;
      lead_one <= (d_exp != '0);
      exp_neg  <= d_exp_neg;
      sig      <= d_sig;
      bin      <= d_mag;
      bcd      <= '0;
      dcnt     <= '0;
      widx     <= '0;
    end else begin
      if (cmd.conv) begin
        {bcd, bin} <= {bcd_adj[BCD_W-2:0], bin, 1'b0};
      end
      // drop leading zero digits of the exponent
      if (cmd.align) begin
        if (bcd[15:12] != '0) begin
          dcnt <= 2'd3;
        end else if (bcd[11:8] != '0) begin
          bcd  <= {bcd[11:0], 4'd0};
          dcnt <= 2'd2;
        end else if (bcd[7:4] != '0) begin
          bcd  <= {bcd[7:0], 8'd0};
          dcnt <= 2'd1;
        end else begin
          bcd  <= {bcd[3:0], 12'd0};
          dcnt <= 2'd0;
        end
      end
      if (cmd.emit && (cmd.sel == SEL_FRAC)) begin
        sig <= {sig[SIG_W-5:0], 4'd0};
      end
      if (cmd.emit && (cmd.sel == SEL_EXP)) begin
        bcd  <= {bcd[BCD_W-5:0], 4'd0};
        dcnt <= dcnt - 2'd1;
      end
      if (cmd.emit && (cmd.sel == SEL_WORD)) begin
        widx <= widx + 3'd1;
      end
    end
  end

  // conversion step counter
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      conv_cnt <= '0;
    end else if (cmd.conv) begin
      conv_cnt <= conv_cnt + 4'd1;
    end
  end

  // character select
  always_comb begin
    case (cmd.sel)
      SEL_MINUS: ch = CH_MINUS;
      SEL_ZERO:  ch = CH_ZERO;
      SEL_X:     ch = CH_X;
      SEL_LEAD:  ch = lead_one ? CH_ONE : CH_ZERO;
      SEL_DOT:   ch = CH_DOT;
      SEL_FRAC:  ch = hex_char(sig[SIG_W-1 -: 4]);
      SEL_P:     ch = CH_P;
      SEL_EXP:   ch = hex_char(bcd[BCD_W-1 -: 4]);
      SEL_WORD:  ch = word_char(is_nan, widx);
      default:   ch = CH_ZERO;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (cmd.emit) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_code <= ch;
      last_char <= cmd.last;
    end
  end

  // status to the controller
  always_comb begin
    stat.out_free  = !char_valid || !char_stall;
    stat.conv_done = (conv_cnt == CONV_STEPS);
    stat.neg       = neg;
    stat.is_nan    = is_nan;
    stat.is_inf    = is_inf;
    stat.exp_neg   = exp_neg;
    stat.frac_last = (sig[SIG_W-5:0] == '0);
    stat.exp_last  = (dcnt == 2'd0);
    stat.word_last = is_nan ? (widx == 3'd2) : (widx == 3'd7);
  end

  // checks
  `IHF_ASSERT_IMP(a_conv_bound, clk, rst, cmd.conv, conv_cnt < CONV_STEPS, "conversion ran too long")
  `IHF_ASSERT_NXT(a_align_lead, clk, rst, cmd.align, (dcnt == 2'd0) || (bcd[15:12] != 4'd0), "exponent not aligned")
  `IHF_ASSERT_NXT(a_emit_valid, clk, rst, cmd.emit, char_valid, "emitted character not presented")

endmodule

`default_nettype wire

// File: rtl/core/ieee_float_hex_string_formatter_core.sv
// IEEE single/double to hexadecimal floating-point text, one character per transfer.
//
// Channels: value_valid/value_stall/value_bits take one raw bit pattern; the
// text leaves on char_valid/char_stall with char_code and last_char, where
// last_char marks the final character. cfg_valid/cfg_ready/precision_mode
// writes the mode (0 single on bits 31..0, 1 double); cfg_ready is always high,
// and the mode should only be changed while no text is in flight.
// Flow: a value is taken while the sequencer is idle, then the exponent goes through an
// 11-step binary to bcd converter plus an alignment step, then one character
// is produced per cycle while the output does not stall. A new value is taken
// only once the whole text of N characters (3 to 24) has been produced.
// A stall on the output holds the current character in the output register and
// freezes the sequencer; value_stall stays high until the text is complete.
// Reset (rst, synchronous) returns the sequencer to idle, empties the output
// register and sets the mode to single precision.
// depends on ihf_pkg, ihf_ctrl and ihf_datapath
`default_nettype none

module ieee_float_hex_string_formatter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        precision_mode,
  input  wire logic        value_valid,
  output logic             value_stall,
  input  wire logic [63:0] value_bits,
  output logic             char_valid,
  input  wire logic        char_stall,
  output logic [6:0]       char_code,
  output logic             last_char
);
  import ihf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // mode register is always writable
  assign cfg_ready = 1'b1;

  // sequencer
  ihf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath
  ihf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_valid && cfg_ready),
    .precision_mode (precision_mode),
    .value_bits     (value_bits),
    .cmd            (cmd),
    .stat           (stat),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_code      (char_code),
    .last_char      (last_char)
  );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench for ieee_float_hex_string_formatter_core: directed and random values in both modes
// checks each character transfer against a text predictor held in a small scoreboard class
// depends only on the core RTL and its package
`timescale 1ns / 1ps

module testbench;

  localparam logic MODE_SINGLE = 1'b0;
  localparam logic MODE_DOUBLE = 1'b1;
  localparam int   CYCLE_LIMIT = 600000;
  localparam int   SETTLE_CYCLES = 20;

  // expected character store and text predictor
  class hex_text_scoreboard;
    logic [6:0] want_code[$];
    logic       want_last[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int pending();
      return want_code.size();
    endfunction

    function void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
        want_code.push_back(7'(s[i]));
        want_last.push_back(1'b0);
      end
    endfunction

    // work out the whole text of one value and queue its characters
    function void note_value(logic [63:0] bits, logic dbl);
      logic        neg;
      int          expo;
      int          exp_top;
      int          bias;
      int          ndig;
      logic [63:0] frac;
      string       sub_txt;
      if (dbl == MODE_SINGLE) begin
        neg     = bits[31];
        expo    = int'(bits[30:23]);
        exp_top = 255;
        frac    = {40'd0, bits[22:0], 1'b0};
        ndig    = 6;
        bias    = 127;
        sub_txt = "p-126";
      end else begin
        neg     = bits[63];
        expo    = int'(bits[62:52]);
        exp_top = 2047;
        frac    = {12'd0, bits[51:0]};
        ndig    = 13;
        bias    = 1023;
        sub_txt = "p-1022";
      end
      if (expo == exp_top) begin
        if (frac != 64'd0) put_text("NaN");
        else if (neg) put_text("-Infinity");
        else put_text("Infinity");
      end else if (expo == 0 && frac == 64'd0) begin
        if (neg) put_text("-0x0.0p0");
        else put_text("0x0.0p0");
      end else begin
        if (neg) put_text("-0x");
        else put_text("0x");
        if (expo == 0) put_text("0.");
        else put_text("1.");
        if (frac == 64'd0) begin
          put_text("0");
        end else begin
          // drop trailing zero nibbles
          while (frac[3:0] == 4'h0) begin
            frac = frac >> 4;
            ndig--;
          end
          for (int i = ndig - 1; i >= 0; i--) begin
            put_text($sformatf("%h", frac[4*i +: 4]));
          end
        end
        if (expo == 0) put_text(sub_txt);
        else put_text($sformatf("p%0d", expo - bias));
      end
      want_last[want_last.size() - 1] = 1'b1;
    endfunction

    // compare one character transfer with the oldest expectation
    function void check_char(logic [6:0] code, logic last);
      logic [6:0] exp_code;
      logic       exp_last;
      if (want_code.size() == 0) begin
        $display("%0t: char with none expected: expected none, actual code %h last %b",
                 $time, code, last);
        mismatches++;
        return;
      end
      exp_code = want_code.pop_front();
      exp_last = want_last.pop_front();
      if (code !== exp_code) begin
        $display("%0t: char_code mismatch: expected %h, actual %h", $time, exp_code, code);
        mismatches++;
      end
      if (last !== exp_last) begin
        $display("%0t: last_char mismatch: expected %b, actual %b", $time, exp_last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        precision_mode = 1'b0;
  logic        value_valid = 1'b0;
  logic        value_stall;
  logic [63:0] value_bits = 64'd0;
  logic        char_valid;
  logic        char_stall = 1'b0;
  logic [6:0]  char_code;
  logic        last_char;

  hex_text_scoreboard sb = new();
  logic mode_now = MODE_SINGLE;
  bit   bursts_on = 1'b1;
  int   cycle_count = 0;

  logic [63:0] single_cases [0:13] = '{
    64'h0000_0000_0000_0000, 64'h0000_0000_8000_0000, 64'h0000_0000_7f80_0000,
    64'h0000_0000_ff80_0000, 64'h0000_0000_7fc0_0000, 64'h0000_0000_ffff_ffff,
    64'h0000_0000_3f80_0000, 64'h0000_0000_0000_0001, 64'h0000_0000_007f_ffff,
    64'h0000_0000_7f7f_ffff, 64'h0000_0000_0080_0000, 64'h0000_0000_bfc0_0000,
    64'hdead_beef_3f80_0000, 64'hffff_ffff_1234_5678
  };

  logic [63:0] double_cases [0:11] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7ff0_0000_0000_0000,
    64'hfff0_0000_0000_0000, 64'h7ff8_0000_0000_0000, 64'hfff0_0000_0000_0001,
    64'h3ff0_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h000f_ffff_ffff_ffff,
    64'h7fef_ffff_ffff_ffff, 64'h0010_0000_0000_0000, 64'hc004_0000_0000_0000
  };

  ieee_float_hex_string_formatter_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .precision_mode (precision_mode),
    .value_valid    (value_valid),
    .value_stall    (value_stall),
    .value_bits     (value_bits),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_code      (char_code),
    .last_char      (last_char)
  );

  always #10 clk = ~clk;

  // transfer monitor on all three channels
  always @(posedge clk) begin
    if (rst) begin
      mode_now <= MODE_SINGLE;
    end else begin
      if (cfg_valid && cfg_ready) mode_now <= precision_mode;
      if (value_valid && !value_stall) sb.note_value(value_bits, mode_now);
      if (char_valid && !char_stall) sb.check_char(char_code, last_char);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        char_stall <= 1'b1;
        repeat (n) @(posedge clk);
        char_stall <= 1'b0;
      end
    end
  end

  task automatic send_value(logic [63:0] bits);
    if (bursts_on && $urandom_range(0, 2) == 0) begin
      value_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    value_valid <= 1'b1;
    value_bits  <= bits;
    do @(posedge clk); while (value_stall);
  endtask

  // hold off the sender until every queued character has come out
  task automatic drain_values();
    value_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_mode(logic m);
    drain_values();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid      <= 1'b1;
    precision_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random pattern biased towards special exponents and short fractions
  function automatic logic [63:0] random_value(logic dbl);
    logic [63:0] v;
    int          pick;
    int          k;
    v    = {$urandom, $urandom};
    pick = $urandom_range(0, 11);
    if (dbl == MODE_SINGLE) begin
      case (pick)
        0: v[30:23] = 8'hff;
        1: v[30:23] = 8'h00;
        2: v[22:0] = 23'd0;
        3: begin
          v[30:23] = 8'h00;
          v[22:0]  = v[22:0] >> $urandom_range(0, 22);
        end
        4, 5: begin
          k       = $urandom_range(0, 22);
          v[22:0] = (v[22:0] >> k) << k;
        end
        6: v[30:23] = 8'(123 + $urandom_range(0, 8));
        7: v[30:23] = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'hfe;
        default: ;
      endcase
    end else begin
      case (pick)
        0: v[62:52] = 11'h7ff;
        1: v[62:52] = 11'h000;
        2: v[51:0] = 52'd0;
        3: begin
          v[62:52] = 11'h000;
          v[51:0]  = v[51:0] >> $urandom_range(0, 51);
        end
        4, 5: begin
          k       = $urandom_range(0, 51);
          v[51:0] = (v[51:0] >> k) << k;
        end
        6: v[62:52] = 11'(1019 + $urandom_range(0, 8));
        7: v[62:52] = ($urandom_range(0, 1) == 0) ? 11'h001 : 11'h7fe;
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic random_phase(logic m, int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_values();
      send_value(random_value(m));
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed values, single then double
    write_mode(MODE_SINGLE);
    foreach (single_cases[i]) send_value(single_cases[i]);
    write_mode(MODE_DOUBLE);
    foreach (double_cases[i]) send_value(double_cases[i]);

    // random values across several mode settings
    random_phase(MODE_DOUBLE, 67);
    write_mode(MODE_SINGLE);
    random_phase(MODE_SINGLE, 67);
    write_mode(MODE_DOUBLE);
    random_phase(MODE_DOUBLE, 35);
    write_mode(MODE_SINGLE);
    bursts_on = 1'b0;
    random_phase(MODE_SINGLE, 35);

    drain_values();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ihf_pkg.sv
rtl/core/ihf_ctrl.sv
rtl/core/ihf_datapath.sv
rtl/core/ieee_float_hex_string_formatter_core.sv
tb/testbench.sv
